// ===== sv/four_function_calculator_entry_core_defines.svh =====
// Assertion macros for the four-function calculator entry core.
`ifndef FOUR_FUNCTION_CALCULATOR_ENTRY_CORE_DEFINES_SVH
`define FOUR_FUNCTION_CALCULATOR_ENTRY_CORE_DEFINES_SVH

// check cons in the same cycle as ante
`define FFC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ffc assertion failed");

// check cons in the cycle after ante
`define FFC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ffc assertion failed");

`endif

// ===== sv/ffc_pkg.sv =====
// Shared types, codes and helpers of the four-function calculator entry core.
`timescale 1ns / 1ps
`default_nettype none
package ffc_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int DISPLAY_WIDTH = 32;
	localparam int DEC_RADIX = 10;

	localparam logic [1:0] KEY_DIGIT    = 2'd0;
	localparam logic [1:0] KEY_OPERATOR = 2'd1;
	localparam logic [1:0] KEY_CLEAR    = 2'd2;
	localparam logic [1:0] KEY_EQUALS   = 2'd3;

	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;

	typedef struct packed {
		logic [1:0] func;
		logic [3:0] digit;
		logic [1:0] operation;
	} key_word_t;

	typedef struct packed {
		logic [DISPLAY_WIDTH-1:0] display_value;
		logic                     divide_error;
	} result_word_t;

	function automatic logic [DISPLAY_WIDTH-1:0] to_display(input logic [VALUE_WIDTH-1:0] v);
		logic [63:0] ext;
		ext = 64'(v);
		return ext[DISPLAY_WIDTH-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== sv/four_function_calculator_entry_core.sv =====
// Four-function keypad calculator core: key decode, sequencer and serial arithmetic unit.
//
// One key word in, one result word out. Digit keys (value * 10 + digit) and
// keys that complete a pending multiply or divide run the shared shift-and-add /
// restoring-divide loop, which retires one multiplier or quotient bit per cycle
// and leaves its result in res_q before the done state moves it to the output
// register. Add, subtract, clear, divide by zero and keys with nothing pending
// set res_q when the key is accepted and go straight to the done state. A new
// key is taken once the previous result sits in the output register; a stalled
// output holds the block after its next result is ready.
`timescale 1ns / 1ps
`default_nettype none
`include "four_function_calculator_entry_core_defines.svh"
module four_function_calculator_entry_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 key_valid,
	output logic                      key_ready,
	input  wire ffc_pkg::key_word_t   key,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output ffc_pkg::result_word_t     result
);

	localparam int W = ffc_pkg::VALUE_WIDTH;
	localparam int CNT_W = $clog2(W);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     first_q, second_q, running_q;
	logic [2:0]       pend_q;
	logic [1:0]       func_q, op_q;
	logic             dst_first_q;
	logic [W-1:0]     acc_q, mpd_q, mlt_q, res_q;
	logic             err_q;
	logic             out_valid_q;
	ffc_pkg::result_word_t out_q;

	logic             key_acc, last, out_free;
	logic [W-1:0]     mul_next;
	logic [W:0]       shifted, trial;
	logic             ge;
	logic [W-1:0]     rem_next, quo_next;

	assign key_ready = (state_q == ST_IDLE);
	assign key_acc = key_valid && key_ready;
	assign last = (cnt_q == CNT_W'(W - 1));
	assign out_free = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;
	assign result = out_q;

	always_comb begin
		mul_next = acc_q + (mlt_q[0] ? mpd_q : '0);
		shifted = {acc_q, mlt_q[W-1]};
		ge = (shifted >= {1'b0, mpd_q});
		trial = shifted - {1'b0, mpd_q};
		rem_next = ge ? trial[W-1:0] : shifted[W-1:0];
		quo_next = {mlt_q[W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			first_q <= '0;
			second_q <= '0;
			running_q <= '0;
			pend_q <= ffc_pkg::OP_NONE;
			func_q <= ffc_pkg::KEY_CLEAR;
			op_q <= '0;
			dst_first_q <= 1'b0;
			acc_q <= '0;
			mpd_q <= '0;
			mlt_q <= '0;
			res_q <= '0;
			err_q <= 1'b0;
			out_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (key_acc) begin
						cnt_q <= '0;
						func_q <= key.func;
						op_q <= key.operation;
						err_q <= 1'b0;
						case (key.func)
							ffc_pkg::KEY_DIGIT: begin
								dst_first_q <= (pend_q == ffc_pkg::OP_NONE);
								mpd_q <= (pend_q == ffc_pkg::OP_NONE) ? first_q : second_q;
								mlt_q <= W'(ffc_pkg::DEC_RADIX);
								acc_q <= W'(key.digit);
								state_q <= ST_MUL;
							end
							ffc_pkg::KEY_CLEAR: begin
								first_q <= '0;
								second_q <= '0;
								running_q <= '0;
								pend_q <= ffc_pkg::OP_NONE;
								res_q <= '0;
								state_q <= ST_DONE;
							end
							default: begin
								case (pend_q)
									ffc_pkg::OP_ADD: begin
										res_q <= running_q + second_q;
										state_q <= ST_DONE;
									end
									ffc_pkg::OP_SUB: begin
										res_q <= running_q - second_q;
										state_q <= ST_DONE;
									end
									ffc_pkg::OP_MUL: begin
										acc_q <= '0;
										mpd_q <= running_q;
										mlt_q <= second_q;
										state_q <= ST_MUL;
									end
									ffc_pkg::OP_DIV: begin
										if (second_q == '0) begin
											res_q <= '1;
											err_q <= 1'b1;
											state_q <= ST_DONE;
										end else begin
											acc_q <= '0;
											mpd_q <= second_q;
											mlt_q <= running_q;
											state_q <= ST_DIV;
										end
									end
									default: begin
										res_q <= running_q;
										state_q <= ST_DONE;
									end
								endcase
							end
						endcase
					end
				end
				ST_MUL: begin
					acc_q <= mul_next;
					mpd_q <= {mpd_q[W-2:0], 1'b0};
					mlt_q <= {1'b0, mlt_q[W-1:1]};
					if (last) begin
						res_q <= mul_next;
						cnt_q <= '0;
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					acc_q <= rem_next;
					mlt_q <= quo_next;
					if (last) begin
						res_q <= quo_next;
						cnt_q <= '0;
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_q.display_value <= ffc_pkg::to_display(res_q);
						out_q.divide_error <= err_q;
						state_q <= ST_IDLE;
						case (func_q)
							ffc_pkg::KEY_DIGIT: begin
								if (dst_first_q) begin
									first_q <= res_q;
									running_q <= res_q;
								end else begin
									second_q <= res_q;
								end
							end
							ffc_pkg::KEY_OPERATOR: begin
								running_q <= res_q;
								pend_q <= 3'(op_q) + ffc_pkg::OP_ADD;
								first_q <= '0;
								second_q <= '0;
							end
							ffc_pkg::KEY_EQUALS: begin
								running_q <= res_q;
								pend_q <= ffc_pkg::OP_NONE;
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`FFC_ASSERT_NOW(a_err_all_ones, result_valid && result.divide_error,
		result.display_value == ffc_pkg::to_display({W{1'b1}}))
	`FFC_ASSERT_NOW(a_idle_cnt_zero, state_q == ST_IDLE, cnt_q == '0)
	`FFC_ASSERT_NEXT(a_busy_after_key, key_acc, !key_ready)
	`FFC_ASSERT_NOW(a_pend_range, 1'b1, pend_q <= ffc_pkg::OP_DIV)

endmodule
`default_nettype wire

// ===== sim/four_function_calculator_entry_core_test.sv =====
// Self-checking testbench for the four-function calculator entry core.
`timescale 1ns / 1ps
module four_function_calculator_entry_core_test;

	localparam logic [1:0] OPER_ADD = 2'd0;
	localparam logic [1:0] OPER_SUB = 2'd1;
	localparam logic [1:0] OPER_MUL = 2'd2;
	localparam logic [1:0] OPER_DIV = 2'd3;

	localparam int VW           = ffc_pkg::VALUE_WIDTH;
	localparam int DW           = ffc_pkg::DISPLAY_WIDTH;
	localparam int RANDOM_KEYS  = 2000;
	localparam int DRAIN_CYCLES = 2 * (VW + 2);
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		ffc_pkg::key_word_t    k;
		logic                  typed;
		ffc_pkg::result_word_t want;
	} key_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  key_valid = 1'b0;
	logic                  key_ready;
	ffc_pkg::key_word_t    key = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	ffc_pkg::result_word_t result;

	logic [VW-1:0] entry_first = '0;
	logic [VW-1:0] entry_second = '0;
	logic [VW-1:0] run_total = '0;
	logic [2:0]    pending_op = ffc_pkg::OP_NONE;

	ffc_pkg::result_word_t expected_results[$];
	key_row_t              directed_rows[$];
	int                    send_idle_pct = 0;
	int                    recv_idle_pct = 0;
	int                    failures = 0;
	int                    cycle_count = 0;

	four_function_calculator_entry_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.key_valid    (key_valid),
		.key_ready    (key_ready),
		.key          (key),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #5 clk = ~clk;

	function automatic logic apply_pending_op();
		logic div_zero;
		div_zero = 1'b0;
		case (pending_op)
			ffc_pkg::OP_ADD: run_total = run_total + entry_second;
			ffc_pkg::OP_SUB: run_total = run_total - entry_second;
			ffc_pkg::OP_MUL: run_total = run_total * entry_second;
			ffc_pkg::OP_DIV: begin
				if (entry_second == '0) begin
					run_total = '1;
					div_zero  = 1'b1;
				end else begin
					run_total = run_total / entry_second;
				end
			end
			default: ;
		endcase
		pending_op = ffc_pkg::OP_NONE;
		return div_zero;
	endfunction

	function automatic ffc_pkg::result_word_t predict_key(input ffc_pkg::key_word_t k);
		ffc_pkg::result_word_t r;
		logic [VW-1:0]         shown;
		logic                  err;
		shown = '0;
		err   = 1'b0;
		case (k.func)
			ffc_pkg::KEY_DIGIT: begin
				if (pending_op == ffc_pkg::OP_NONE) begin
					entry_first = entry_first * VW'(ffc_pkg::DEC_RADIX) + VW'(k.digit);
					run_total   = entry_first;
					shown       = entry_first;
				end else begin
					entry_second = entry_second * VW'(ffc_pkg::DEC_RADIX)
						+ VW'(k.digit);
					shown = entry_second;
				end
			end
			ffc_pkg::KEY_OPERATOR: begin
				err   = apply_pending_op();
				shown = run_total;
				case (k.operation)
					OPER_ADD: pending_op = ffc_pkg::OP_ADD;
					OPER_SUB: pending_op = ffc_pkg::OP_SUB;
					OPER_MUL: pending_op = ffc_pkg::OP_MUL;
					default:  pending_op = ffc_pkg::OP_DIV;
				endcase
				entry_first  = '0;
				entry_second = '0;
			end
			ffc_pkg::KEY_CLEAR: begin
				entry_first  = '0;
				entry_second = '0;
				run_total    = '0;
				pending_op   = ffc_pkg::OP_NONE;
			end
			default: begin
				err   = apply_pending_op();
				shown = run_total;
			end
		endcase
		r.display_value = DW'(shown);
		r.divide_error  = err;
		return r;
	endfunction

	function automatic ffc_pkg::key_word_t random_key();
		ffc_pkg::key_word_t k;
		int                 pick;
		pick = $urandom_range(99);
		if ($urandom_range(9) == 0)
			k.digit = 4'($urandom_range(15, 10));
		else
			k.digit = 4'($urandom_range(9));
		k.operation = 2'($urandom_range(3));
		if (pick < 55)
			k.func = ffc_pkg::KEY_DIGIT;
		else if (pick < 80)
			k.func = ffc_pkg::KEY_OPERATOR;
		else if (pick < 96)
			k.func = ffc_pkg::KEY_EQUALS;
		else
			k.func = ffc_pkg::KEY_CLEAR;
		return k;
	endfunction

	task automatic add_row(input logic [1:0] f, input logic [3:0] d, input logic [1:0] o,
		input logic typed = 1'b0, input logic [DW-1:0] v = '0,
		input logic e = 1'b0);
		key_row_t row;
		row.k.func            = f;
		row.k.digit           = d;
		row.k.operation       = o;
		row.typed             = typed;
		row.want.display_value = v;
		row.want.divide_error  = e;
		directed_rows.push_back(row);
	endtask

	// call at a falling edge; return at the falling edge after the word is taken
	task automatic send_key(input ffc_pkg::key_word_t k, input logic typed,
		input ffc_pkg::result_word_t typed_want);
		ffc_pkg::result_word_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			key_valid <= 1'b0;
			@(negedge clk);
		end
		key       <= k;
		key_valid <= 1'b1;
		do @(posedge clk); while (!key_ready);
		want = predict_key(k);
		expected_results.push_back(typed ? typed_want : want);
		@(negedge clk);
	endtask

	task automatic note_failure(input string what, input ffc_pkg::result_word_t want,
		input ffc_pkg::result_word_t got);
		failures++;
		if (failures <= MAX_REPORTS)
			$display("cycle %0d: %s: expected value %h error %b, got value %h error %b",
				cycle_count, what, want.display_value, want.divide_error,
				got.display_value, got.divide_error);
	endtask

	always @(negedge clk)
		result_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin : check_results
		ffc_pkg::result_word_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				note_failure("unexpected result word", '0, result);
			end else begin
				want = expected_results.pop_front();
				if (result.display_value !== want.display_value)
					note_failure("display_value mismatch", want, result);
				else if (result.divide_error !== want.divide_error)
					note_failure("divide_error mismatch", want, result);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** four_function_calculator_entry_core: FAILED **");
			$finish;
		end
	end

	initial begin : stimulus
		int phase;
		add_row(ffc_pkg::KEY_CLEAR,    4'd0,  OPER_ADD, 1'b1, '0);
		add_row(ffc_pkg::KEY_DIGIT,    4'd9,  OPER_ADD, 1'b1, 32'd9);
		add_row(ffc_pkg::KEY_DIGIT,    4'd15, OPER_SUB);
		add_row(ffc_pkg::KEY_EQUALS,   4'd0,  OPER_ADD);
		add_row(ffc_pkg::KEY_OPERATOR, 4'd0,  OPER_DIV);
		add_row(ffc_pkg::KEY_EQUALS,   4'd0,  OPER_ADD, 1'b1, '1, 1'b1);
		add_row(ffc_pkg::KEY_DIGIT,    4'd7,  OPER_MUL);
		add_row(ffc_pkg::KEY_OPERATOR, 4'd0,  OPER_ADD);
		add_row(ffc_pkg::KEY_DIGIT,    4'd15, OPER_ADD);
		add_row(ffc_pkg::KEY_OPERATOR, 4'd0,  OPER_SUB);
		add_row(ffc_pkg::KEY_OPERATOR, 4'd15, OPER_MUL);
		repeat (10) add_row(ffc_pkg::KEY_DIGIT, 4'd9, OPER_DIV);
		add_row(ffc_pkg::KEY_OPERATOR, 4'd0,  OPER_DIV);
		add_row(ffc_pkg::KEY_DIGIT,    4'd0,  OPER_ADD);
		add_row(ffc_pkg::KEY_EQUALS,   4'd0,  OPER_ADD, 1'b1, '1, 1'b1);
		add_row(ffc_pkg::KEY_CLEAR,    4'd15, OPER_DIV, 1'b1, '0);
		add_row(ffc_pkg::KEY_EQUALS,   4'd15, OPER_DIV, 1'b1, '0);

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 21;
		recv_idle_pct = 77;
		foreach (directed_rows[i])
			send_key(directed_rows[i].k, directed_rows[i].typed, directed_rows[i].want);

		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 77 : 0;
			recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 21 : 0;
			repeat (RANDOM_KEYS / 3)
				send_key(random_key(), 1'b0, '0);
		end
		key_valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0 && expected_results.size() == 0)
			$display("** four_function_calculator_entry_core: PASSED **");
		else
			$display("** four_function_calculator_entry_core: FAILED **");
		$finish;
	end

endmodule
